// ===== rtl/atsu_pkg.sv =====
// ----------------------------------------------------------------------------
// atsu_pkg: shared types, constants and stage functions
// Stage layout of the arctangent pipeline and the per-stage payload record.
// ----------------------------------------------------------------------------
package atsu_pkg;

  localparam int unsigned DIV_STAGES = 16;  // two quotient bits per stage
  localparam int unsigned ST_IN  = 0;
  localparam int unsigned ST_U   = DIV_STAGES + 1;
  localparam int unsigned ST_U2  = ST_U + 1;
  localparam int unsigned ST_U3  = ST_U2 + 1;
  localparam int unsigned ST_T3  = ST_U3 + 1;
  localparam int unsigned ST_T5  = ST_T3 + 1;
  localparam int unsigned ST_T7  = ST_T5 + 1;
  localparam int unsigned ST_T9  = ST_T7 + 1;
  localparam int unsigned ST_OUT = ST_T9 + 1;
  localparam int unsigned NUM_ST = ST_OUT + 1;

  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
  localparam logic [32:0] HALF_PI_Q32 = 33'h1_921F_B544;

  // floor(t/d) = (t*m) >> s, exact for any 33-bit t
  localparam int unsigned SH3 = 35;
  localparam int unsigned SH5 = 36;
  localparam int unsigned SH7 = 36;
  localparam int unsigned SH9 = 37;
  localparam logic [34:0] RCP3 = 35'(((64'd1 << SH3) + 64'd2) / 64'd3);
  localparam logic [34:0] RCP5 = 35'(((64'd1 << SH5) + 64'd4) / 64'd5);
  localparam logic [34:0] RCP7 = 35'(((64'd1 << SH7) + 64'd6) / 64'd7);
  localparam logic [34:0] RCP9 = 35'(((64'd1 << SH9) + 64'd8) / 64'd9);

  typedef struct packed {
    logic        neg;
    logic        recip;
    logic [31:0] mag;
    logic [32:0] rem;
    logic [31:0] quo;
    logic [32:0] u;
    logic [32:0] u2;
    logic [32:0] pw;
    logic [35:0] acc;
    logic [29:0] angle;
  } pipe_t;

  function automatic logic [32:0] const_div(input logic [32:0] t,
                                            input logic [34:0] m,
                                            input int unsigned sh);
    logic [67:0] prod;
    prod = {35'd0, t} * {33'd0, m};
    prod = prod >> sh;
    return prod[32:0];
  endfunction

  function automatic pipe_t take_input(input logic [31:0] x);
    pipe_t p;
    p       = '0;
    p.neg   = x[31];
    p.mag   = x[31] ? (~x + 32'd1) : x;
    p.recip = (p.mag > ONE_Q16);
    p.rem   = {1'b0, ONE_Q16};  // 2^48 / 2^32
    return p;
  endfunction

  // two restoring steps of 2^48 / mag; dividend bits below 2^32 are zero
  function automatic pipe_t div_step2(input pipe_t p);
    pipe_t       n;
    logic [32:0] t;
    n = p;
    for (int i = 0; i < 2; i++) begin
      t = {n.rem[31:0], 1'b0};
      if (t >= {1'b0, n.mag}) begin
        n.rem = t - {1'b0, n.mag};
        n.quo = {n.quo[30:0], 1'b1};
      end else begin
        n.rem = t;
        n.quo = {n.quo[30:0], 1'b0};
      end
    end
    return n;
  endfunction

  function automatic pipe_t pick_u(input pipe_t p);
    pipe_t n;
    n   = p;
    n.u = p.recip ? {1'b0, p.quo} : {p.mag[16:0], 16'd0};
    return n;
  endfunction

  function automatic pipe_t finish(input pipe_t p);
    pipe_t       n;
    logic [32:0] res;
    logic [29:0] r;
    n       = p;
    res     = p.recip ? (HALF_PI_Q32 - p.acc[32:0]) : p.acc[32:0];
    r       = {1'b0, res[32:4]};
    n.angle = p.neg ? (30'd0 - r) : r;
    return n;
  endfunction

endpackage

// ===== rtl/arctangent_series_unit_core.sv =====
// ----------------------------------------------------------------------------
// arctangent_series_unit_core: pipelined five-term arctangent
// Signed Q16.16 argument in, signed Q2.28 angle in radians out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel : x_value with in_valid / in_ready.
//   Output channel: angle with out_valid / out_ready.
//   One result item per input item, in order.
// Pipeline: 25 register stages (1 capture stage, 16 divider stages, 8 series /
//   output stages); out_valid is the valid bit of the last stage.
// Throughput: one item per cycle while the output is not stalled; the divider
//   stages and the chain of Q32 multipliers are fully pipelined, each stage
//   one multiply or two divider steps deep.
// |x| <= 1 runs the series on |x|; |x| > 1 runs it on 1/|x| (quotient
//   from the restoring divider) and reflects off pi/2. Sign applied last.
// Stalls: each stage holds its item while the stage ahead is full and
//   stalled; empty stages keep filling, so bubbles collapse and the input
//   keeps taking items until the pipe is completely full.
// Reset: clears all stage valid bits; the pipe is empty and in_ready is
//   high in the first cycle after reset.
// ----------------------------------------------------------------------------
module arctangent_series_unit_core
  import atsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] x_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] angle
);

  pipe_t             pipe [NUM_ST];
  pipe_t             pipe_next [NUM_ST];
  logic [NUM_ST-1:0] vld;
  logic [NUM_ST:0]   adv;   // stage may load

  logic [32:0] m_u2, m_u3, m_u5, m_u7, m_u9;

  // ready chain: a stage loads when empty or when the stage ahead loads
  assign adv[NUM_ST] = out_ready;
  for (genvar k = 0; k < NUM_ST; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[ST_OUT];
  assign angle     = pipe[ST_OUT].angle;

  // powers of u: u^2, u^3, then u^5, u^7, u^9 alongside the term sums
  atsu_mulq u_mul_u2 (.a(pipe[ST_U].u),   .b(pipe[ST_U].u),   .y(m_u2));
  atsu_mulq u_mul_u3 (.a(pipe[ST_U2].u2), .b(pipe[ST_U2].u),  .y(m_u3));
  atsu_mulq u_mul_u5 (.a(pipe[ST_U3].pw), .b(pipe[ST_U3].u2), .y(m_u5));
  atsu_mulq u_mul_u7 (.a(pipe[ST_T3].pw), .b(pipe[ST_T3].u2), .y(m_u7));
  atsu_mulq u_mul_u9 (.a(pipe[ST_T5].pw), .b(pipe[ST_T5].u2), .y(m_u9));

  always_comb begin
    // capture: sign, magnitude, path select, divider seed
    pipe_next[ST_IN] = take_input(x_value);

    // 2^48 / |x|, two quotient bits per stage
    for (int g = 1; g <= int'(DIV_STAGES); g++) begin
      pipe_next[g] = div_step2(pipe[g-1]);
    end

    pipe_next[ST_U] = pick_u(pipe[ST_U-1]);

    pipe_next[ST_U2]    = pipe[ST_U];
    pipe_next[ST_U2].u2 = m_u2;

    pipe_next[ST_U3]    = pipe[ST_U2];
    pipe_next[ST_U3].pw = m_u3;

    // the running sum wraps mod 2^36; the final value is a true magnitude
    pipe_next[ST_T3]     = pipe[ST_U3];
    pipe_next[ST_T3].acc = {3'd0, pipe[ST_U3].u}
                         - {3'd0, const_div(pipe[ST_U3].pw, RCP3, SH3)};
    pipe_next[ST_T3].pw  = m_u5;

    pipe_next[ST_T5]     = pipe[ST_T3];
    pipe_next[ST_T5].acc = pipe[ST_T3].acc
                         + {3'd0, const_div(pipe[ST_T3].pw, RCP5, SH5)};
    pipe_next[ST_T5].pw  = m_u7;

    pipe_next[ST_T7]     = pipe[ST_T5];
    pipe_next[ST_T7].acc = pipe[ST_T5].acc
                         - {3'd0, const_div(pipe[ST_T5].pw, RCP7, SH7)};
    pipe_next[ST_T7].pw  = m_u9;

    pipe_next[ST_T9]     = pipe[ST_T7];
    pipe_next[ST_T9].acc = pipe[ST_T7].acc
                         + {3'd0, const_div(pipe[ST_T7].pw, RCP9, SH9)};

    pipe_next[ST_OUT] = finish(pipe[ST_T9]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_ST; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_ST; k++) begin
      if (adv[k]) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  // result stays within +-pi/2
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(angle) <= 30'sd421657428) &&
                  ($signed(angle) >= -30'sd421657428))
    else $error("angle beyond pi/2");

  // divider remainder stays below the divisor on the reciprocal path
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[ST_U-1] && pipe[ST_U-1].recip |-> pipe[ST_U-1].rem < {1'b0, pipe[ST_U-1].mag})
    else $error("divider remainder out of range");

  // series sum is a magnitude no larger than 2^33 once complete
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_T9] |-> pipe[ST_T9].acc[35:33] == 3'd0)
    else $error("series sum wrapped");

endmodule

// ===== rtl/atsu_mulq.sv =====
// ----------------------------------------------------------------------------
// atsu_mulq: Q1.32 magnitude multiply
// y = floor(a*b / 2^32) for operands up to 2^32.
// ----------------------------------------------------------------------------
module atsu_mulq
  import atsu_pkg::*;
(
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [32:0] y
);

  logic [65:0] prod;

  assign prod = a * b;
  assign y    = prod[64:32];

endmodule
